// ----- rtl/mmau_pkg.sv -----
// ============================================================================
// mmau_pkg
// Shared constants, codes and types of the memory map access unit.
// ============================================================================
`default_nettype none

package mmau_pkg;

    // Region sizes in bytes
    localparam int unsigned FLASH_DEPTH  = 128 * 1024;
    localparam int unsigned SRAM_DEPTH   = 16 * 1024;
    localparam int unsigned SYSTEM_DEPTH = 1024 * 1024;
    localparam int unsigned ALIAS_DEPTH  = 128 * 1024;

    // Region bases
    localparam logic [31:0] ALIAS_BASE  = 32'h0000_0000;
    localparam logic [31:0] FLASH_BASE  = 32'h0800_0000;
    localparam logic [31:0] SRAM_BASE   = 32'h2000_0000;
    localparam logic [31:0] SYSTEM_BASE = 32'hE000_0000;

    // Byte lanes of a 32-bit word
    localparam int unsigned LANES = 4;

    localparam int unsigned MAX_DEPTH =
        (FLASH_DEPTH > SRAM_DEPTH)
            ? ((FLASH_DEPTH > SYSTEM_DEPTH) ? FLASH_DEPTH : SYSTEM_DEPTH)
            : ((SRAM_DEPTH > SYSTEM_DEPTH) ? SRAM_DEPTH : SYSTEM_DEPTH);

    localparam int unsigned OFS_W = $clog2(MAX_DEPTH);
    localparam int unsigned ROW_W = OFS_W - 2;

    localparam int unsigned FLASH_ROWS  = (FLASH_DEPTH + LANES - 1) / LANES;
    localparam int unsigned SRAM_ROWS   = (SRAM_DEPTH + LANES - 1) / LANES;
    localparam int unsigned SYSTEM_ROWS = (SYSTEM_DEPTH + LANES - 1) / LANES;
    localparam int unsigned MAX_ROWS    = (MAX_DEPTH + LANES - 1) / LANES;
    localparam int unsigned CLR_W       = $clog2(MAX_ROWS);

    localparam int unsigned STORE_COUNT = 3;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // Access size codes; anything above halfword is a word
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    localparam logic ACT_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_ADDR    = 2'd1,
        ST_NOT_ALIGNED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        STORE_FLASH  = 2'd0,
        STORE_SRAM   = 2'd1,
        STORE_SYSTEM = 2'd2
    } t_store;

    typedef enum logic {
        CLR_SWEEP,
        CLR_DONE
    } t_clr_state;

    // One classified access, lane-ordered
    typedef struct packed {
        t_store             store;
        t_status            status;
        logic               is_write;
        logic [ROW_W-1:0]   row;       // row of the first byte
        logic [1:0]         lane_off;  // lane of the first byte
        logic [LANES-1:0]   lane_en;   // lanes touched by the access
        logic [31:0]        wdata;     // store data rotated onto lanes
    } t_entry;

    function automatic int unsigned store_rows(input int unsigned st);
        case (st)
            0:       return FLASH_ROWS;
            1:       return SRAM_ROWS;
            default: return SYSTEM_ROWS;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mmau_if.sv -----
// ============================================================================
// mmau_if
// Request and response channels of the memory map access unit.
// ============================================================================
`default_nettype none

interface mmau_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [1:0]  access_size;
    logic        check_alignment;
    logic [31:0] address;
    logic [31:0] write_data;

    modport source (
        output valid, action, access_size, check_alignment, address, write_data,
        input  ready
    );
    modport sink (
        input  valid, action, access_size, check_alignment, address, write_data,
        output ready
    );
endinterface

interface mmau_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [1:0]  status;

    modport source (
        output valid, read_data, status,
        input  ready
    );
    modport sink (
        input  valid, read_data, status,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/mmau_ram.sv -----
// ============================================================================
// mmau_ram
// Single-port RAM with registered read data.
// ============================================================================
`default_nettype none

module mmau_ram #(
    parameter  int unsigned DEPTH  = 1024,
    parameter  int unsigned DATA_W = 8,
    localparam int unsigned AW     = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/mmau_front.sv -----
// ============================================================================
// mmau_front
// Alignment check, region decode and lane steering of each bus word.
// ============================================================================
`default_nettype none

module mmau_front import mmau_pkg::*; (
    mmau_req_if.sink  i_req,
    input  wire logic i_busy,
    input  wire logic i_full,
    output logic      o_push,
    output t_entry    o_entry
);

    localparam logic [32:0] ALIAS_LIMIT  = 33'(ALIAS_BASE) + 33'(ALIAS_DEPTH);
    localparam logic [32:0] FLASH_LIMIT  = 33'(FLASH_BASE) + 33'(FLASH_DEPTH);
    localparam logic [32:0] SRAM_LIMIT   = 33'(SRAM_BASE) + 33'(SRAM_DEPTH);
    localparam logic [32:0] SYSTEM_LIMIT = 33'(SYSTEM_BASE) + 33'(SYSTEM_DEPTH);

    logic [2:0]  len;
    logic [1:0]  align_mask;
    logic        misalign;
    logic [32:0] a_end;
    logic        alias_hit;
    logic [31:0] eff;
    logic [32:0] eff_end;
    logic        hit_flash;
    logic        hit_sram;
    logic        hit_sys;
    logic [31:0] base;
    logic [31:0] offset;

    always_comb begin
        case (i_req.access_size)
            SIZE_BYTE: begin
                len        = 3'd1;
                align_mask = 2'b00;
            end
            SIZE_HALF: begin
                len        = 3'd2;
                align_mask = 2'b01;
            end
            default: begin
                len        = 3'd4;
                align_mask = 2'b11;
            end
        endcase

        misalign = i_req.check_alignment && ((i_req.address[1:0] & align_mask) != 2'b00);

        // alias window redirects onto flash at the same offset
        a_end     = {1'b0, i_req.address} + {30'd0, len};
        alias_hit = (i_req.address >= ALIAS_BASE) && (a_end <= ALIAS_LIMIT);
        eff       = alias_hit ? (i_req.address - ALIAS_BASE + FLASH_BASE) : i_req.address;
        eff_end   = {1'b0, eff} + {30'd0, len};

        hit_flash = (eff >= FLASH_BASE)  && (eff_end <= FLASH_LIMIT);
        hit_sram  = (eff >= SRAM_BASE)   && (eff_end <= SRAM_LIMIT);
        hit_sys   = (eff >= SYSTEM_BASE) && (eff_end <= SYSTEM_LIMIT);
    end

    always_comb begin
        logic [1:0] idx;

        idx = 2'd0;
        o_entry.is_write = (i_req.action == ACT_WRITE);

        if (hit_flash) begin
            o_entry.store = STORE_FLASH;
            base          = FLASH_BASE;
        end else if (hit_sram) begin
            o_entry.store = STORE_SRAM;
            base          = SRAM_BASE;
        end else begin
            o_entry.store = STORE_SYSTEM;
            base          = SYSTEM_BASE;
        end

        if (misalign) begin
            o_entry.status = ST_NOT_ALIGNED;
        end else if (hit_flash || hit_sram || hit_sys) begin
            o_entry.status = ST_OK;
        end else begin
            o_entry.status = ST_BAD_ADDR;
        end

        offset           = eff - base;
        o_entry.row      = offset[OFS_W-1:2];
        o_entry.lane_off = offset[1:0];

        // byte i of the word lands on lane (offset + i) mod 4
        for (int l = 0; l < LANES; l++) begin
            idx                  = 2'(l) - offset[1:0];
            o_entry.lane_en[l]   = ({1'b0, idx} < len);
            o_entry.wdata[8*l +: 8] = i_req.write_data[{idx, 3'b000} +: 8];
        end
    end

    assign i_req.ready = !i_busy && !i_full;
    assign o_push      = i_req.valid && !i_busy && !i_full;

endmodule

`default_nettype wire

// ----- rtl/mmau_queue.sv -----
// ============================================================================
// mmau_queue
// Short FIFO of classified words between the front and the back.
// ============================================================================
`default_nettype none

module mmau_queue import mmau_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_entry    i_entry,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_entry    o_entry
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic [QPTR_W-1:0]   n_rd_ptr;
    logic [QPTR_W:0]     n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// ----- rtl/mmau_back.sv -----
// ============================================================================
// mmau_back
// Byte-lane banks of flash, SRAM and system space, clearing sweep,
// read-data stage and response register.
// ============================================================================
`default_nettype none

module mmau_back import mmau_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  t_entry      i_entry,
    output logic        o_pop,
    output logic        o_busy,
    mmau_rsp_if.source  o_rsp
);

    t_clr_state         r_clr_state;
    t_clr_state         n_clr_state;
    logic [CLR_W-1:0]   r_clr_row;
    logic [CLR_W-1:0]   n_clr_row;
    logic               clearing;

    logic               r_pend_valid;
    t_entry             r_pend;
    logic               r_out_valid;
    logic [31:0]        r_out_rdata;
    t_status            r_out_status;

    logic               issue;
    logic               pend_adv;
    logic               access_ok;
    logic [ROW_W-1:0]   lane_row [LANES];
    logic [7:0]         lane_q   [STORE_COUNT][LANES];
    logic [7:0]         sel_q    [LANES];
    logic [31:0]        rdata;

    // clearing sweep after reset
    always_comb begin
        n_clr_state = r_clr_state;
        unique case (r_clr_state)
            CLR_SWEEP: begin
                if (r_clr_row == CLR_W'(MAX_ROWS - 1)) begin
                    n_clr_state = CLR_DONE;
                end
            end
            CLR_DONE: n_clr_state = CLR_DONE;
        endcase
    end

    always_comb begin
        unique case (r_clr_state)
            CLR_SWEEP: clearing = 1'b1;
            CLR_DONE:  clearing = 1'b0;
        endcase
    end

    assign n_clr_row = clearing ? r_clr_row + 1'b1 : r_clr_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_state <= CLR_SWEEP;
            r_clr_row   <= '0;
        end else begin
            r_clr_state <= n_clr_state;
            r_clr_row   <= n_clr_row;
        end
    end

    // issue / stage control
    assign pend_adv  = r_pend_valid && (!r_out_valid || o_rsp.ready);
    assign issue     = i_valid && !clearing && (!r_pend_valid || pend_adv);
    assign access_ok = (i_entry.status == ST_OK);
    assign o_pop     = issue;
    assign o_busy    = clearing;

    // lanes below the first byte's lane wrap into the next row
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            lane_row[l] = i_entry.row + ROW_W'(2'(l) < i_entry.lane_off);
        end
    end

    for (genvar s = 0; s < STORE_COUNT; s++) begin : g_store
        localparam int unsigned ROWS = store_rows(s);
        localparam int unsigned AW   = $clog2(ROWS);

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic          sel;
            logic          en;
            logic          we;
            logic [AW-1:0] addr;
            logic [7:0]    wd;

            always_comb begin
                sel = issue && access_ok && (i_entry.store == t_store'(s));
                if (clearing) begin
                    en   = (32'(r_clr_row) < ROWS);
                    we   = en;
                    addr = r_clr_row[AW-1:0];
                    wd   = '0;
                end else begin
                    en   = sel;
                    we   = sel && i_entry.is_write && i_entry.lane_en[l];
                    addr = lane_row[l][AW-1:0];
                    wd   = i_entry.wdata[8*l +: 8];
                end
            end

            mmau_ram #(
                .DEPTH  (ROWS),
                .DATA_W (8)
            ) u_ram (
                .i_clk   (i_clk),
                .i_en    (en),
                .i_we    (we),
                .i_addr  (addr),
                .i_wdata (wd),
                .o_rdata (lane_q[s][l])
            );
        end
    end

    // pick the bank row of the pending word and undo the lane rotation
    always_comb begin
        logic [1:0] src;

        src = 2'd0;
        for (int l = 0; l < LANES; l++) begin
            case (r_pend.store)
                STORE_FLASH: sel_q[l] = lane_q[0][l];
                STORE_SRAM:  sel_q[l] = lane_q[1][l];
                default:     sel_q[l] = lane_q[2][l];
            endcase
        end
        for (int i = 0; i < LANES; i++) begin
            src             = 2'(i) + r_pend.lane_off;
            rdata[8*i +: 8] = r_pend.lane_en[src] ? sel_q[src] : 8'd0;
        end
        if (r_pend.is_write || (r_pend.status != ST_OK)) begin
            rdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (issue) begin
                r_pend_valid <= 1'b1;
            end else if (pend_adv) begin
                r_pend_valid <= 1'b0;
            end
            if (pend_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend <= i_entry;
        end
        if (pend_adv) begin
            r_out_rdata  <= rdata;
            r_out_status <= r_pend.status;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out_rdata;
    assign o_rsp.status    = r_out_status;

endmodule

`default_nettype wire

// ----- rtl/memory_map_access_unit_core.sv -----
// ============================================================================
// memory_map_access_unit_core
// Bus access unit: four-region decoder with alias remap onto flash.
// ============================================================================
// Each request word is one read or write of a byte, halfword or word at a
// 32-bit byte address, little-endian. With check_alignment set, a halfword
// or word at an address that is not a multiple of its size returns status
// "not aligned"; otherwise the whole access must fit inside one region
// (alias at 0, flash at 0x0800_0000, SRAM at 0x2000_0000, system space at
// 0xE000_0000), or it returns "invalid address" and nothing is stored. The
// alias window maps onto flash at the same offset. Every request gets one
// response word; read_data is zero for writes and faults. Each store is held
// as four byte-lane banks, so unaligned accesses take a single bank access,
// and the unit sustains one word per clock while responses are taken. A
// request is written into the queue, then read from the banks as its
// entry moves into the pending register, then held in the response
// register. After reset the banks are swept to zero, one row of four bytes
// a cycle over the largest store (MAX_ROWS = 262144 rows at the default
// sizes); ready stays low in the sweep. The front decodes into a two-word
// queue so requests keep moving until it fills while responses are stalled.
// ============================================================================
`default_nettype none

module memory_map_access_unit_core import mmau_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mmau_req_if.sink   i_req,
    mmau_rsp_if.source o_rsp
);

    logic   busy;
    logic   full;
    logic   push;
    t_entry push_entry;
    logic   q_valid;
    t_entry q_entry;
    logic   pop;

    // decode and lane steering
    mmau_front u_front (
        .i_req   (i_req),
        .i_busy  (busy),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    // decoupling queue
    mmau_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // banks, sweep and response
    mmau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (q_entry),
        .o_pop   (pop),
        .o_busy  (busy),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire
